// ===== rtl/ape_pkg.sv =====
// package for the ambisonic panner encoder: widths, register indexes, constants
package ape_pkg;

    localparam int SampleBits = 16;
    localparam int NumOut     = 7;
    localparam int Iter       = 18;
    localparam int CfgIdxBits = 2;

    typedef enum logic [CfgIdxBits-1:0] {
        REG_POS_X  = 2'd0,
        REG_POS_Y  = 2'd1,
        REG_HEIGHT = 2'd2,
        REG_ORDER  = 2'd3
    } cfg_reg_t;

    // gain engine phases
    typedef enum logic [1:0] {PH_IDLE, PH_AZ, PH_ROT, PH_MUL} gain_phase_t;

    localparam logic signed [33:0] W_GAIN   = 34'sd759135470;
    localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
    localparam logic signed [33:0] Q30_ONE  = 34'sd1073741824;

    typedef struct packed {
        logic signed [33:0] cx;
        logic signed [33:0] sy;
    } trig_t;

    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] t;
        unique case (i)
            0:  t = 32'd536870912;
            1:  t = 32'd316933406;
            2:  t = 32'd167458907;
            3:  t = 32'd85004756;
            4:  t = 32'd42667331;
            5:  t = 32'd21354465;
            6:  t = 32'd10679838;
            7:  t = 32'd5340245;
            8:  t = 32'd2670163;
            9:  t = 32'd1335087;
            10: t = 32'd667544;
            11: t = 32'd333772;
            12: t = 32'd166886;
            13: t = 32'd83443;
            14: t = 32'd41721;
            15: t = 32'd20860;
            16: t = 32'd10430;
            default: t = 32'd5215;
        endcase
        return t;
    endfunction

    // rounded q30 product of two narrow signed values
    function automatic logic signed [33:0] rnd30(input logic signed [33:0] a,
                                                 input logic signed [33:0] b);
        logic signed [67:0] p;
        p = a * b + 68'sd536870912;
        return p[63:30];
    endfunction

endpackage

// ===== rtl/ape_gains.sv =====
// configuration-side gain engine: serial cordic for azimuth and sin/cos tables
module ape_gains import ape_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic        [15:0] height,
    output logic               busy,
    output logic signed [33:0] gain_x,
    output logic signed [33:0] gain_y,
    output logic signed [33:0] gain_c2,
    output logic signed [33:0] gain_s2,
    output logic signed [33:0] gain_c3,
    output logic signed [33:0] gain_s3,
    output logic signed [33:0] gain_se
);
    // phases: azimuth vectoring, then rotations for el, az, 2az, 3az, then products
    gain_phase_t        ph_reg, ph_next;
    logic [4:0]         it_reg;
    logic [2:0]         job_reg;
    logic signed [35:0] x_reg, y_reg;
    logic signed [33:0] z_reg;
    logic               flip_reg;
    logic [31:0]        az_reg;
    trig_t              el_reg, a1_reg, a2_reg, a3_reg;
    logic signed [33:0] ce2_reg;
    logic [2:0]         mstep_reg;
    logic [31:0]        ang;
    logic               fl;
    logic [31:0]        red;
    logic [31:0]        at;
    logic [31:0]        at_rot;

    assign at     = atan_turn(int'(it_reg));
    assign at_rot = atan_turn(int'(it_reg) - 1);
    assign busy   = (ph_reg != PH_IDLE) || start;

    always_comb begin
        unique case (job_reg)
            3'd0:    ang = {1'b0, height, 15'd0} - 32'h4000_0000;
            3'd1:    ang = az_reg;
            3'd2:    ang = {az_reg[30:0], 1'b0};
            default: ang = az_reg + {az_reg[30:0], 1'b0};
        endcase
        fl  = (ang - 32'h4000_0000) < 32'h8000_0000;
        red = fl ? ang - 32'h8000_0000 : ang;
    end

    always_comb begin
        ph_next = ph_reg;
        if (start) begin
            ph_next = PH_AZ;
        end else begin
            unique case (ph_reg)
                PH_IDLE: ph_next = PH_IDLE;
                PH_AZ:   if (it_reg == 5'(Iter)) ph_next = PH_ROT;
                PH_ROT:  if (it_reg == 5'(Iter) + 5'd1 && job_reg == 3'd3) ph_next = PH_MUL;
                default: if (mstep_reg == 3'd6) ph_next = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) ph_reg <= PH_IDLE;
        else          ph_reg <= ph_next;
    end

    always_ff @(posedge aclk) begin
        if (start || ph_reg == PH_IDLE) begin
            // a new start reloads from the current registers
            it_reg    <= '0;
            job_reg   <= '0;
            mstep_reg <= '0;
            if (pos_x < 0) begin
                x_reg <= -(36'(pos_x) <<< 14);
                y_reg <= -(36'(pos_y) <<< 14);
                az_reg <= 32'h8000_0000;
            end else begin
                x_reg <= 36'(pos_x) <<< 14;
                y_reg <= 36'(pos_y) <<< 14;
                az_reg <= '0;
            end
        end else begin
            unique case (ph_reg)
                PH_AZ: begin
                    if (it_reg == 5'(Iter)) begin
                        it_reg <= '0;
                        if (pos_x == 0)
                            az_reg <= (pos_y > 0) ? 32'h4000_0000 : 32'hC000_0000;
                        else if (pos_y == 0)
                            az_reg <= (pos_x > 0) ? 32'h0 : 32'h8000_0000;
                    end else begin
                        it_reg <= it_reg + 5'd1;
                        if (y_reg >= 0) begin
                            x_reg <= x_reg + (y_reg >>> it_reg);
                            y_reg <= y_reg - (x_reg >>> it_reg);
                            az_reg <= az_reg + at;
                        end else begin
                            x_reg <= x_reg - (y_reg >>> it_reg);
                            y_reg <= y_reg + (x_reg >>> it_reg);
                            az_reg <= az_reg - at;
                        end
                    end
                end
                PH_ROT: begin
                    if (it_reg == 5'd0) begin
                        // load start vector for this job
                        x_reg    <= 36'(CORDIC_K);
                        y_reg    <= '0;
                        z_reg    <= 34'(signed'(red));
                        flip_reg <= fl;
                        it_reg   <= 5'd1;
                    end else if (it_reg == 5'(Iter) + 5'd1) begin
                        unique case (job_reg)
                            3'd0: el_reg <= {flip_reg ? -34'(x_reg) : 34'(x_reg),
                                             flip_reg ? -34'(y_reg) : 34'(y_reg)};
                            3'd1: a1_reg <= {flip_reg ? -34'(x_reg) : 34'(x_reg),
                                             flip_reg ? -34'(y_reg) : 34'(y_reg)};
                            3'd2: a2_reg <= {flip_reg ? -34'(x_reg) : 34'(x_reg),
                                             flip_reg ? -34'(y_reg) : 34'(y_reg)};
                            default: a3_reg <= {flip_reg ? -34'(x_reg) : 34'(x_reg),
                                                flip_reg ? -34'(y_reg) : 34'(y_reg)};
                        endcase
                        job_reg <= job_reg + 3'd1;
                        it_reg  <= '0;
                    end else begin
                        it_reg <= it_reg + 5'd1;
                        if (z_reg >= 0) begin
                            x_reg <= x_reg - (y_reg >>> (it_reg - 5'd1));
                            y_reg <= y_reg + (x_reg >>> (it_reg - 5'd1));
                            z_reg <= z_reg - 34'(at_rot);
                        end else begin
                            x_reg <= x_reg + (y_reg >>> (it_reg - 5'd1));
                            y_reg <= y_reg - (x_reg >>> (it_reg - 5'd1));
                            z_reg <= z_reg + 34'(at_rot);
                        end
                    end
                end
                default: begin
                    mstep_reg <= mstep_reg + 3'd1;
                    if (height == 16'd0)
                        el_reg <= {Q30_ONE, Q30_ONE};
                    unique case (mstep_reg)
                        3'd0: ce2_reg <= (height == 16'd0) ? Q30_ONE
                                         : rnd30(el_reg.cx, el_reg.cx);
                        3'd1: gain_x  <= rnd30(a1_reg.cx, el_reg.cx);
                        3'd2: gain_y  <= rnd30(a1_reg.sy, el_reg.cx);
                        3'd3: begin
                            gain_c2 <= rnd30(a2_reg.cx, ce2_reg);
                            gain_s2 <= rnd30(a2_reg.sy, ce2_reg);
                            ce2_reg <= rnd30(ce2_reg, el_reg.cx);
                        end
                        3'd4: begin
                            gain_c3 <= rnd30(a3_reg.cx, ce2_reg);
                            gain_s3 <= rnd30(a3_reg.sy, ce2_reg);
                        end
                        default: gain_se <= el_reg.sy;
                    endcase
                end
            endcase
        end
    end

endmodule

// ===== rtl/ambisonic_panner_encoder_top.sv =====
// top level of the ambisonic panner encoder
//  channel | dir | beat fields
//  s_axis  | in  | tdata: sample[15:0]
//  cfg     | in  | index[1:0], data[15:0]
//  m_axis  | out | tdata: w, x, y, fourth, v, p, q (16 bits each, lowest first)
// one sample per cycle unless m_axis stalls or a config update is pending; data passes
// the sample, multiply and clamp stages. a config write starts the serial gain engine;
// samples wait meanwhile. reset is synchronous; a stall on m_axis freezes every stage.
module ambisonic_panner_encoder_top import ape_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // sample
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata,   // w, x, y, fourth, v, p, q
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    logic signed [15:0] pos_x_reg, pos_y_reg;
    logic [15:0]        height_reg;
    logic [1:0]         order_reg;
    logic               start_reg, busy;
    logic signed [33:0] g [NumOut];
    logic signed [33:0] gx, gy, gc2, gs2, gc3, gs3, gse;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg <= '0; pos_y_reg <= '0; height_reg <= '0; order_reg <= 2'd1;
            start_reg <= 1'b1;
        end else begin
            start_reg <= cfg_valid;
            if (cfg_valid) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_POS_X:  pos_x_reg  <= cfg_data;
                    REG_POS_Y:  pos_y_reg  <= cfg_data;
                    REG_HEIGHT: height_reg <= cfg_data;
                    default:    order_reg  <= cfg_data[1:0];
                endcase
            end
        end
    end

    ape_gains u_gains (
        .aclk, .aresetn, .start(start_reg),
        .pos_x(pos_x_reg), .pos_y(pos_y_reg), .height(height_reg), .busy,
        .gain_x(gx), .gain_y(gy), .gain_c2(gc2), .gain_s2(gs2),
        .gain_c3(gc3), .gain_s3(gs3), .gain_se(gse)
    );

    // gain selection by order
    always_comb begin
        g[0] = W_GAIN; g[1] = gx; g[2] = gy;
        g[3] = (order_reg <= 2'd1) ? gse : gc2;
        g[4] = (order_reg <= 2'd1) ? '0 : gs2;
        g[5] = (order_reg == 2'd3) ? gc3 : '0;
        g[6] = (order_reg == 2'd3) ? gs3 : '0;
    end

    logic       v1_reg, v2_reg, v3_reg;
    logic       adv;
    logic signed [15:0] smp_reg;
    logic signed [49:0] prod_reg [NumOut];
    logic signed [15:0] res_reg  [NumOut];

    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv && !busy && !cfg_valid;
    assign m_axis_tvalid = v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_axis_tvalid && s_axis_tready;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            smp_reg <= s_axis_tdata;
            for (int j = 0; j < NumOut; j++) begin
                prod_reg[j] <= 50'(smp_reg) * 50'(g[j]) + 50'sd536870912;
                if ($signed(prod_reg[j][49:30]) > 20'sd32767)
                    res_reg[j] <= 16'sh7fff;
                else if ($signed(prod_reg[j][49:30]) < -20'sd32768)
                    res_reg[j] <= 16'sh8000;
                else
                    res_reg[j] <= prod_reg[j][45:30];
            end
        end
    end

    always_comb begin
        for (int j = 0; j < NumOut; j++) m_axis_tdata[16*j +: 16] = res_reg[j];
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !(s_axis_tvalid && s_axis_tready)) else $error("accept while busy");
    a_valid_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && v2_reg) |=> v3_reg) else $error("beat lost");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output changed under stall");

endmodule
